### hdl/signed_varint_decoder_defines.svh
// Assertion helpers used by the decoder top level.
`ifndef SIGNED_VARINT_DECODER_DEFINES_SVH
`define SIGNED_VARINT_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SVD_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("signed_varint_decoder: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SVD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("signed_varint_decoder: next-cycle check failed");

`endif

### hdl/svd_pkg.sv
`default_nettype none
package svd_pkg;

   // Decoded number width and derived sizes
   localparam int VALUE_WIDTH = 64;
   localparam int OUT_WIDTH   = 64;
   localparam int DIGIT_BITS  = 7;
   localparam int MAX_BYTES   = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int IDX_WIDTH   = $clog2(MAX_BYTES);
   localparam int SHIFT_WIDTH = $clog2(DIGIT_BITS * MAX_BYTES + 1);
   localparam int PAD_BITS    = OUT_WIDTH - VALUE_WIDTH;
   localparam int COUNT_WIDTH = 4;
   localparam int MAXLEN_WIDTH = 31;
   localparam int MODE_WIDTH  = 2;

   // Range check modes; the unused code behaves as raw
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_RAW    = 2'd0,
      MODE_LENGTH = 2'd1,
      MODE_ID     = 2'd2
   } svd_mode_type;

   // Register indexes (address bit 2)
   localparam logic REG_CHECK_MODE = 1'b0;
   localparam logic REG_MAX_LENGTH = 1'b1;

   // Classified byte handed from front to back
   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic [IDX_WIDTH-1:0]  index;
      logic                  last;
      logic                  at_limit;
      logic                  more;
   } svd_item_type;

   // Finished number
   typedef struct packed {
      logic [OUT_WIDTH-1:0]   value;
      logic                   range_error;
      logic                   unterminated;
      logic [COUNT_WIDTH-1:0] byte_count;
   } svd_result_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [MODE_WIDTH-1:0]   mode;
      logic [MAXLEN_WIDTH-1:0] max_length;
   } svd_cfg_type;

endpackage
`default_nettype wire

### hdl/svd_front.sv
`default_nettype none
module svd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  wire  [7:0]            data_byte,
   output logic                  mid_valid,
   output svd_pkg::svd_item_type mid_item,
   input  wire                   mid_pop
);
   import svd_pkg::*;

   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   svd_item_type         q_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 accept;
   svd_item_type         item;

   assign full      = (count_ff == 2'd2);
   assign accept    = push && !full;
   assign mid_valid = (count_ff != 2'd0);
   assign mid_item  = q_ff[rd_ptr_ff];

   // Classify the incoming byte by its place in the number
   always_comb begin
      item.digit    = data_byte[DIGIT_BITS-1:0];
      item.index    = idx_ff;
      item.more     = data_byte[7];
      item.at_limit = (idx_ff == IDX_WIDTH'(MAX_BYTES - 1));
      item.last     = !data_byte[7] || item.at_limit;
   end

   // Advance the byte index, restart it after the last byte, and update the queue pointers
   always_comb begin
      idx_in    = idx_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         idx_in    = item.last ? '0 : idx_ff + 1'b1;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (mid_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (accept && !mid_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!accept && mid_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         idx_ff    <= idx_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold classified bytes for the back end
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

### hdl/svd_back.sv
`default_nettype none
module svd_back (
   input  wire                     clock,
   input  wire                     reset,
   input  svd_pkg::svd_cfg_type    cfg,
   input  wire                     mid_valid,
   input  svd_pkg::svd_item_type   mid_item,
   output logic                    mid_pop,
   output logic                    empty,
   input  wire                     pop,
   output svd_pkg::svd_result_type rsp
);
   import svd_pkg::*;

   logic [VALUE_WIDTH-1:0]            acc_ff, acc_in;
   svd_result_type                    q_ff [2];
   logic                              wr_ptr_ff, wr_ptr_in;
   logic                              rd_ptr_ff, rd_ptr_in;
   logic [1:0]                        count_ff, count_in;
   logic                              take, rsp_push, rsp_pop;
   logic [SHIFT_WIDTH-1:0]            shift_amt, fill_bits;
   logic [VALUE_WIDTH+DIGIT_BITS-1:0] placed;
   logic [VALUE_WIDTH-1:0]            merged;
   logic [OUT_WIDTH-1:0]              widened, hi_mask, limit_value, short_value, value;
   logic                              range_error;
   svd_result_type                    result;

   // Take a byte unless it finishes a number and the result queue is full
   assign take     = mid_valid && (!mid_item.last || count_ff != 2'd2);
   assign mid_pop  = take;
   assign rsp_push = take && mid_item.last;
   assign empty    = (count_ff == 2'd0);
   assign rsp_pop  = pop && !empty;
   assign rsp      = q_ff[rd_ptr_ff];

   // Place the seven payload bits and sign extend a finished number
   always_comb begin
      shift_amt   = SHIFT_WIDTH'(mid_item.index) * SHIFT_WIDTH'(DIGIT_BITS);
      fill_bits   = shift_amt + SHIFT_WIDTH'(DIGIT_BITS);
      placed      = (VALUE_WIDTH + DIGIT_BITS)'(mid_item.digit) << shift_amt;
      merged      = acc_ff | placed[VALUE_WIDTH-1:0];
      widened     = OUT_WIDTH'(merged);
      limit_value = OUT_WIDTH'($signed(widened << PAD_BITS) >>> PAD_BITS);
      hi_mask     = ~OUT_WIDTH'(0) << fill_bits;
      short_value = mid_item.digit[DIGIT_BITS-1] ? (widened | hi_mask) : widened;
      value       = mid_item.at_limit ? limit_value : short_value;
   end

   // Check the range of the current mode
   always_comb begin
      case (cfg.mode)
         MODE_LENGTH: range_error = value[OUT_WIDTH-1] ||
                                    (value > OUT_WIDTH'(cfg.max_length));
         MODE_ID:     range_error = !((&value[OUT_WIDTH-1:31]) || !(|value[OUT_WIDTH-1:31]));
         default:     range_error = 1'b0;
      endcase
   end

   always_comb begin
      result.value        = value;
      result.range_error  = range_error;
      result.unterminated = mid_item.at_limit && mid_item.more;
      result.byte_count   = COUNT_WIDTH'(mid_item.index) + COUNT_WIDTH'(1);
   end

   // Advance the accumulator and the result queue pointers
   always_comb begin
      acc_in    = acc_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         acc_in = mid_item.last ? '0 : merged;
      end
      if (rsp_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (rsp_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (rsp_push && !rsp_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!rsp_push && rsp_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         acc_ff    <= acc_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold finished numbers until popped
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

endmodule
`default_nettype wire

### hdl/signed_varint_decoder.sv
// A result shows (empty low) once its last byte has left the byte queue and its result has
// been written to the result queue. Throughput: one byte per cycle while full is low; the
// two-entry queues after the byte classifier and after the accumulator let each side stall on its own.
// A number ends after a byte with bit 7 clear or after the tenth byte.
// Reset (synchronous, active high) empties both queues, clears the accumulator
// and byte index, and sets check_mode to raw and max_length to 2147483647.
`default_nettype none
`include "signed_varint_decoder_defines.svh"
module signed_varint_decoder (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                push,
   output logic               full,
   input  wire  [7:0]         req_data_byte,
   // result channel
   output logic               empty,
   input  wire                pop,
   output logic signed [63:0] rsp_decoded_value,
   output logic               rsp_range_error,
   output logic               rsp_unterminated,
   output logic [3:0]         rsp_byte_count,
   // register port
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import svd_pkg::*;

   logic [MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic [MAXLEN_WIDTH-1:0] max_length_ff, max_length_in;
   logic                    csr_write;
   svd_cfg_type             cfg;
   logic                    mid_valid, mid_pop;
   svd_item_type            mid_item;
   svd_result_type          rsp;

   // Register writes and reads
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in       = mode_ff;
      max_length_in = max_length_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_CHECK_MODE: mode_in       = pwdata[MODE_WIDTH-1:0];
            REG_MAX_LENGTH: max_length_in = pwdata[MAXLEN_WIDTH-1:0];
            default:        mode_in       = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_CHECK_MODE: prdata = 32'(mode_ff);
         REG_MAX_LENGTH: prdata = 32'(max_length_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RAW;
         max_length_ff <= '1;
      end else begin
         mode_ff       <= mode_in;
         max_length_ff <= max_length_in;
      end
   end

   assign cfg.mode       = mode_ff;
   assign cfg.max_length = max_length_ff;

   // Classify bytes
   svd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .data_byte (req_data_byte),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop)
   );

   // Accumulate, extend and range check
   svd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_decoded_value = $signed(rsp.value);
   assign rsp_range_error   = rsp.range_error;
   assign rsp_unterminated  = rsp.unterminated;
   assign rsp_byte_count    = rsp.byte_count;

   // Byte count of a waiting result stays within one to the byte limit
   `SVD_ASSERT_NOW(a_count_range, !empty,
      (rsp_byte_count != 4'd0) && (rsp_byte_count <= COUNT_WIDTH'(MAX_BYTES)))

   // Only a number cut at the byte limit is unterminated
   `SVD_ASSERT_NOW(a_unterm_at_limit, !empty && rsp_unterminated,
      rsp_byte_count == COUNT_WIDTH'(MAX_BYTES))

   // A full byte queue stays full until the back end drains it
   `SVD_ASSERT_NEXT(a_full_holds, full && !mid_pop, full)

endmodule
`default_nettype wire
